/* rtl/dnsqp_pkg.sv */
package dnsqp_pkg;

	localparam int unsigned HeaderBytes = 12;
	localparam logic [7:0] MaxLabel = 8'd63;
	localparam logic [7:0] SeparatorChar = 8'h2e;
	localparam logic [15:0] TypeA = 16'd1;
	localparam int unsigned QueueDepth = 4;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_LEN     = 3'd1,
		PH_LABEL   = 3'd2,
		PH_TYPE_HI = 3'd3,
		PH_TYPE_LO = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		V_OK     = 3'd0,
		V_COUNTS = 3'd1,
		V_LABEL  = 3'd2,
		V_NOT_A  = 3'd3,
		V_LONG   = 3'd4,
		V_TRUNC  = 3'd5
	} verdict_t;

	// one queued entry: an optional host character followed by an optional verdict
	typedef struct packed {
		logic       ch_v;
		logic [7:0] ch;
		logic       vd_v;
		verdict_t   vd;
		logic [7:0] name_length;
		logic [15:0] query_id;
	} entry_t;

	typedef struct packed {
		logic   empty;
		entry_t head;
	} queue_stat_t;

endpackage

/* rtl/dnsqp_byte_if.sv */
interface dnsqp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_packet;

	modport source (output valid, output data_byte, output end_of_packet, input ready);
	modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

/* rtl/dnsqp_result_if.sv */
interface dnsqp_result_if;
	logic        valid;
	logic        ready;
	logic        is_verdict;
	logic [7:0]  host_char;
	logic [2:0]  verdict;
	logic [7:0]  name_length;
	logic [15:0] query_id;

	modport source (output valid, output is_verdict, output host_char, output verdict,
		output name_length, output query_id, input ready);
	modport sink (input valid, input is_verdict, input host_char, input verdict,
		input name_length, input query_id, output ready);
endinterface

/* rtl/dnsqp_front.sv */
module dnsqp_front #(
	parameter int unsigned MAX_NAME = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	dnsqp_byte_if.sink          req,
	input  logic                queue_full,
	output logic                push,
	output dnsqp_pkg::entry_t   push_entry
);

	localparam logic [7:0] MaxName = 8'(MAX_NAME);

	logic [3:0]        hdr_pos_q, hdr_pos_d;
	dnsqp_pkg::phase_t phase_q, phase_d;
	logic [5:0]        label_rem_q, label_rem_d;
	logic [7:0]        host_count_q, host_count_d;
	logic [15:0]       id_q, id_d;
	logic [7:0]        cnt_hi_q, cnt_hi_d;
	logic              counts_ok_q, counts_ok_d;
	logic              first_q, first_d;

	logic              accept;
	logic [7:0]        b;
	logic [15:0]       full_word;
	logic              ch_v;
	logic [7:0]        ch;
	logic              vd_v;
	dnsqp_pkg::verdict_t vd;
	logic [5:0]        rem_dec;
	logic              hdr_last;
	logic              name_full;
	logic              bad_len;

	assign req.ready = !queue_full;
	assign accept    = req.valid && req.ready;
	assign b         = req.data_byte;
	assign full_word = {cnt_hi_q, b};
	assign rem_dec   = label_rem_q - 6'd1;
	assign hdr_last  = 32'(hdr_pos_q) + 32'd1 >= dnsqp_pkg::HeaderBytes;
	assign name_full = host_count_q >= MaxName;
	assign bad_len   = b > dnsqp_pkg::MaxLabel || (b == 8'd0 && first_q);

	// next state
	always_comb begin
		hdr_pos_d    = hdr_pos_q;
		phase_d      = phase_q;
		label_rem_d  = label_rem_q;
		host_count_d = host_count_q;
		id_d         = id_q;
		cnt_hi_d     = cnt_hi_q;
		counts_ok_d  = counts_ok_q;
		first_d      = first_q;

		case (phase_q)
			dnsqp_pkg::PH_HEADER: begin
				if (hdr_pos_q == 4'd0) begin
					id_d[15:8] = b;
				end else if (hdr_pos_q == 4'd1) begin
					id_d[7:0] = b;
				end else if (hdr_pos_q >= 4'd4 && !hdr_pos_q[0]) begin
					cnt_hi_d = b;
				end else if (hdr_pos_q == 4'd5) begin
					if (full_word != 16'd1) counts_ok_d = 1'b0;
				end else if (hdr_pos_q == 4'd7 || hdr_pos_q == 4'd9) begin
					if (full_word != 16'd0) counts_ok_d = 1'b0;
				end else if (hdr_pos_q == 4'd11) begin
					if (full_word > 16'd1) counts_ok_d = 1'b0;
				end
				if (hdr_last) begin
					hdr_pos_d = 4'd0;
					if (!counts_ok_d) phase_d = dnsqp_pkg::PH_DONE;
					else phase_d = dnsqp_pkg::PH_LEN;
				end else begin
					hdr_pos_d = hdr_pos_q + 4'd1;
				end
			end
			dnsqp_pkg::PH_LEN: begin
				if (bad_len) begin
					phase_d = dnsqp_pkg::PH_DONE;
				end else if (b == 8'd0) begin
					phase_d = dnsqp_pkg::PH_TYPE_HI;
				end else begin
					first_d = 1'b0;
					if (!first_q && name_full) begin
						phase_d = dnsqp_pkg::PH_DONE;
					end else begin
						label_rem_d = b[5:0];
						phase_d     = dnsqp_pkg::PH_LABEL;
						if (!first_q) host_count_d = host_count_q + 8'd1;
					end
				end
			end
			dnsqp_pkg::PH_LABEL: begin
				if (name_full) begin
					phase_d = dnsqp_pkg::PH_DONE;
				end else begin
					host_count_d = host_count_q + 8'd1;
					label_rem_d  = rem_dec;
					if (rem_dec == 6'd0) phase_d = dnsqp_pkg::PH_LEN;
				end
			end
			dnsqp_pkg::PH_TYPE_HI: begin
				cnt_hi_d = b;
				phase_d  = dnsqp_pkg::PH_TYPE_LO;
			end
			dnsqp_pkg::PH_TYPE_LO: begin
				phase_d = dnsqp_pkg::PH_DONE;
			end
			default: begin
			end
		endcase
	end

	// outputs
	always_comb begin
		ch_v = 1'b0;
		ch   = b;
		vd_v = 1'b0;
		vd   = dnsqp_pkg::V_OK;

		case (phase_q)
			dnsqp_pkg::PH_HEADER: begin
				if (hdr_last && !counts_ok_d) begin
					vd_v = 1'b1;
					vd   = dnsqp_pkg::V_COUNTS;
				end
			end
			dnsqp_pkg::PH_LEN: begin
				if (bad_len) begin
					vd_v = 1'b1;
					vd   = dnsqp_pkg::V_LABEL;
				end else if (b != 8'd0 && !first_q) begin
					if (name_full) begin
						vd_v = 1'b1;
						vd   = dnsqp_pkg::V_LONG;
					end else begin
						ch_v = 1'b1;
						ch   = dnsqp_pkg::SeparatorChar;
					end
				end
			end
			dnsqp_pkg::PH_LABEL: begin
				if (name_full) begin
					vd_v = 1'b1;
					vd   = dnsqp_pkg::V_LONG;
				end else begin
					ch_v = 1'b1;
				end
			end
			dnsqp_pkg::PH_TYPE_LO: begin
				vd_v = 1'b1;
				vd   = (full_word == dnsqp_pkg::TypeA) ? dnsqp_pkg::V_OK
					: dnsqp_pkg::V_NOT_A;
			end
			default: begin
			end
		endcase

		// early end of packet: verdict follows any character of this byte
		if (req.end_of_packet && phase_d != dnsqp_pkg::PH_DONE) begin
			vd_v = 1'b1;
			vd   = dnsqp_pkg::V_TRUNC;
		end
	end

	assign push                   = accept && (ch_v || vd_v);
	assign push_entry.ch_v        = ch_v;
	assign push_entry.ch          = ch_v ? ch : 8'd0;
	assign push_entry.vd_v        = vd_v;
	assign push_entry.vd          = vd;
	assign push_entry.name_length = host_count_d;
	assign push_entry.query_id    = id_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q    <= '0;
			phase_q      <= dnsqp_pkg::PH_HEADER;
			label_rem_q  <= '0;
			host_count_q <= '0;
			id_q         <= '0;
			cnt_hi_q     <= '0;
			counts_ok_q  <= 1'b1;
			first_q      <= 1'b1;
		end else if (accept) begin
			if (req.end_of_packet) begin
				hdr_pos_q    <= '0;
				phase_q      <= dnsqp_pkg::PH_HEADER;
				label_rem_q  <= '0;
				host_count_q <= '0;
				id_q         <= '0;
				cnt_hi_q     <= '0;
				counts_ok_q  <= 1'b1;
				first_q      <= 1'b1;
			end else begin
				hdr_pos_q    <= hdr_pos_d;
				phase_q      <= phase_d;
				label_rem_q  <= label_rem_d;
				host_count_q <= host_count_d;
				id_q         <= id_d;
				cnt_hi_q     <= cnt_hi_d;
				counts_ok_q  <= counts_ok_d;
				first_q      <= first_d;
			end
		end
	end

endmodule

/* rtl/dnsqp_queue.sv */
module dnsqp_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  dnsqp_pkg::entry_t        push_entry,
	output logic                     full,
	input  logic                     pop,
	output dnsqp_pkg::queue_stat_t   stat
);

	localparam int unsigned PtrW = $clog2(dnsqp_pkg::QueueDepth);
	localparam int unsigned CntW = $clog2(dnsqp_pkg::QueueDepth + 1);

	dnsqp_pkg::entry_t slot_q [dnsqp_pkg::QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = count_q == CntW'(dnsqp_pkg::QueueDepth);
	assign stat.empty = count_q == '0;
	assign stat.head  = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/dnsqp_back.sv */
module dnsqp_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dnsqp_pkg::queue_stat_t   stat,
	output logic                     pop,
	dnsqp_result_if.source           res
);

	dnsqp_pkg::entry_t cur_q;
	logic              ch_pend_q;
	logic              vd_pend_q;
	logic              busy;
	logic              taken;
	logic              last;

	assign busy  = ch_pend_q || vd_pend_q;
	assign taken = res.valid && res.ready;
	assign last  = !(ch_pend_q && vd_pend_q);
	assign pop   = !stat.empty && (!busy || (taken && last));

	assign res.valid       = busy;
	assign res.is_verdict  = !ch_pend_q;
	assign res.host_char   = ch_pend_q ? cur_q.ch : 8'd0;
	assign res.verdict     = ch_pend_q ? 3'd0 : cur_q.vd;
	assign res.name_length = ch_pend_q ? 8'd0 : cur_q.name_length;
	assign res.query_id    = ch_pend_q ? 16'd0 : cur_q.query_id;

	always_ff @(posedge clk) begin
		if (pop) cur_q <= stat.head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_pend_q <= 1'b0;
			vd_pend_q <= 1'b0;
		end else if (pop) begin
			ch_pend_q <= stat.head.ch_v;
			vd_pend_q <= stat.head.vd_v;
		end else if (taken) begin
			if (ch_pend_q) ch_pend_q <= 1'b0;
			else vd_pend_q <= 1'b0;
		end
	end

endmodule

/* rtl/dns_query_name_parser_top.sv */
// channel | dir | payload
// req     | in  | data_byte, end_of_packet
// res     | out | is_verdict, host_char, verdict, name_length, query_id
//
// one byte is parsed per cycle in the front end unless the queue is full; each
// byte queues at most one entry holding a host character and/or a verdict; the output
// stage sends the character first when an entry has both (a truncated packet)
// a four-entry queue separates parsing from delivery, so res stalls reach req only
// when it fills
// arst_n clears all parser and queue state; no clearing pass is needed
module dns_query_name_parser_top #(
	parameter int unsigned MAX_NAME = 255
) (
	input  logic           clk,
	input  logic           arst_n,
	dnsqp_byte_if.sink     req,
	dnsqp_result_if.source res
);

	logic                   push;
	dnsqp_pkg::entry_t      push_entry;
	logic                   full;
	logic                   pop;
	dnsqp_pkg::queue_stat_t stat;

	dnsqp_front #(
		.MAX_NAME(MAX_NAME)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.queue_full (full),
		.push       (push),
		.push_entry (push_entry)
	);

	dnsqp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.stat       (stat)
	);

	dnsqp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.pop    (pop),
		.res    (res)
	);

endmodule
